[hdl/planar_arm_tip_and_direction_assert.svh]
// Assertion macros for the arm tip block.
`ifndef PLANAR_ARM_TIP_AND_DIRECTION_ASSERT_SVH
`define PLANAR_ARM_TIP_AND_DIRECTION_ASSERT_SVH
`ifndef ASSERT_OFF
`define PATD_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define PATD_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define PATD_ASSERT_IMP(label, clk, rst_n, a, b)
`define PATD_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

[hdl/patd_pkg.sv]
`timescale 1ns / 1ps
package patd_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int COORD_BITS   = 24;
    localparam int LEN_BITS     = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int XY_BITS      = 34;
    localparam int Z_BITS       = 32;
    localparam int CS_BITS      = 32;
    localparam int PROD_BITS    = LEN_BITS + 1 + CS_BITS;
    localparam int RND_BITS     = COORD_BITS + 30;
    localparam int LANES        = 3;
    localparam int REG_INDEX_BITS = 2;
    // input stage, CORDIC steps, quadrant, multiply, round, output
    localparam int STAGES       = CORDIC_STEPS + 5;

    localparam logic signed [XY_BITS-1:0] CORDIC_GAIN = XY_BITS'(32'h26DD3B6A);
    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    localparam logic [REG_INDEX_BITS-1:0] REG_LINK_LENGTH = 2'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_BASE_HEIGHT = 2'd1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] base_x;
        logic signed [COORD_BITS-1:0] base_y;
        logic [ANGLE_BITS-1:0]        joint_angle_one;
        logic [ANGLE_BITS-1:0]        joint_angle_two;
        logic [ANGLE_BITS-1:0]        joint_angle_three;
    } item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] tip_x;
        logic signed [COORD_BITS-1:0] tip_y;
        logic [ANGLE_BITS-1:0]        direction;
    } result_t;

    typedef struct packed {
        logic signed [XY_BITS-1:0] x;
        logic signed [XY_BITS-1:0] y;
        logic signed [Z_BITS-1:0]  z;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0]            lane;
        logic [LANES-1:0][1:0]        quad;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] ty;
        logic [ANGLE_BITS-1:0]        dir;
    } stage_t;

    function automatic logic signed [Z_BITS-1:0] atan_step(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return $signed(v);
    endfunction

    // Q30 product to whole units of the length, halves away from zero, wrapped to coordinate width
    function automatic logic signed [COORD_BITS-1:0] round_q30(
        input logic signed [PROD_BITS-1:0] v);
        logic signed [RND_BITS-1:0] w;
        logic [RND_BITS-1:0]        mag;
        logic [RND_BITS-1:0]        sum;
        logic [COORD_BITS-1:0]      r;
        w   = RND_BITS'(v);
        mag = w[RND_BITS-1] ? RND_BITS'(-w) : RND_BITS'(w);
        sum = mag + (RND_BITS'(1) << 29);
        r   = sum[RND_BITS-1:30];
        return w[RND_BITS-1] ? $signed(-r) : $signed(r);
    endfunction

endpackage

[hdl/planar_arm_tip_and_direction.sv]
`timescale 1ns / 1ps
// Channel   Handshake                    Payload
// item      item_valid / item_stall      item   (base_x, base_y, three joint angles)
// result    result_valid / result_stall  result (tip_x, tip_y, direction)
// cfg       cfg_write                    cfg_index, cfg_data
//
// Pipeline stages: input stage, 30 CORDIC steps, quadrant fold, multiply, round, sum.
// One transaction per cycle while result_stall is low; the three joint angles run in parallel CORDIC lanes.
// Each stage moves when it is empty or the next one moves, so bubbles close up.
// rst_n clears the stage valid bits and both registers to zero.
module planar_arm_tip_and_direction
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  patd_pkg::item_t                      item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output patd_pkg::result_t                    result,
    input  logic                                 cfg_write,
    input  logic [patd_pkg::REG_INDEX_BITS-1:0]  cfg_index,
    input  logic [patd_pkg::LEN_BITS-1:0]        cfg_data
);

    `include "planar_arm_tip_and_direction_assert.svh"

    localparam int QS = patd_pkg::CORDIC_STEPS + 1;
    localparam int MS = patd_pkg::CORDIC_STEPS + 2;
    localparam int RS = patd_pkg::CORDIC_STEPS + 3;
    localparam int OS = patd_pkg::CORDIC_STEPS + 4;

    logic [patd_pkg::LEN_BITS-1:0] link_length_reg;
    logic [patd_pkg::LEN_BITS-1:0] base_height_reg;

    logic [patd_pkg::STAGES-1:0] valid_reg;
    logic [patd_pkg::STAGES-1:0] move;

    patd_pkg::stage_t st0_reg;
    patd_pkg::stage_t st0_next;
    patd_pkg::stage_t st [patd_pkg::CORDIC_STEPS+1];

    logic signed [patd_pkg::CS_BITS-1:0] c_reg [patd_pkg::LANES];
    logic signed [patd_pkg::CS_BITS-1:0] s_reg [patd_pkg::LANES];
    logic signed [patd_pkg::CS_BITS-1:0] c_next [patd_pkg::LANES];
    logic signed [patd_pkg::CS_BITS-1:0] s_next [patd_pkg::LANES];
    logic signed [patd_pkg::COORD_BITS-1:0] rc [patd_pkg::LANES];
    logic signed [patd_pkg::COORD_BITS-1:0] rs [patd_pkg::LANES];

    logic signed [patd_pkg::COORD_BITS-1:0] bx_reg [QS:RS];
    logic signed [patd_pkg::COORD_BITS-1:0] ty_reg [QS:RS];
    logic [patd_pkg::ANGLE_BITS-1:0]        dir_reg [QS:RS];

    patd_pkg::result_t result_reg;
    patd_pkg::result_t result_next;

    // configuration; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_length_reg <= '0;
            base_height_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                patd_pkg::REG_LINK_LENGTH: link_length_reg <= cfg_data;
                patd_pkg::REG_BASE_HEIGHT: base_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage advance chain, from the output back
    always_comb
    begin
        move[patd_pkg::STAGES-1] = !valid_reg[patd_pkg::STAGES-1] || !result_stall;
        for (int i = patd_pkg::STAGES - 2; i >= 0; i--)
        begin
            move[i] = !valid_reg[i] || move[i+1];
        end
    end

    assign item_stall = !move[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (move[0])
            begin
                valid_reg[0] <= item_valid;
            end
            for (int i = 1; i < patd_pkg::STAGES; i++)
            begin
                if (move[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // input stage: running angle sums, quadrant split, CORDIC seed
    always_comb
    begin
        logic [patd_pkg::ANGLE_BITS-1:0] a [patd_pkg::LANES];
        a[0] = item.joint_angle_one;
        a[1] = a[0] + item.joint_angle_two;
        a[2] = a[1] + item.joint_angle_three;
        for (int l = 0; l < patd_pkg::LANES; l++)
        begin
            st0_next.lane[l].x = patd_pkg::CORDIC_GAIN;
            st0_next.lane[l].y = '0;
            st0_next.lane[l].z = $signed({2'b00, a[l][patd_pkg::ANGLE_BITS-3:0],
                                          {(patd_pkg::Z_BITS-patd_pkg::ANGLE_BITS){1'b0}}});
            st0_next.quad[l]   = a[l][patd_pkg::ANGLE_BITS-1 -: 2];
        end
        st0_next.bx  = item.base_x;
        st0_next.ty  = item.base_y
                     + $signed(patd_pkg::COORD_BITS'(base_height_reg));
        st0_next.dir = (link_length_reg == '0) ? '0 : a[2] + patd_pkg::QUARTER_TURN;
    end

    always_ff @(posedge clk)
    begin
        if (move[0])
        begin
            st0_reg <= st0_next;
        end
    end

    assign st[0] = st0_reg;

    for (genvar i = 0; i < patd_pkg::CORDIC_STEPS; i++)
    begin : g_step
        patd_cordic_step u_step
        (
            .clk  (clk),
            .en   (move[i+1]),
            .step (5'(i)),
            .d    (st[i]),
            .q    (st[i+1])
        );
    end

    // quadrant fold
    always_comb
    begin
        patd_pkg::lane_t ln;
        logic signed [patd_pkg::XY_BITS-1:0] cw;
        logic signed [patd_pkg::XY_BITS-1:0] sw;
        for (int l = 0; l < patd_pkg::LANES; l++)
        begin
            ln = st[patd_pkg::CORDIC_STEPS].lane[l];
            case (st[patd_pkg::CORDIC_STEPS].quad[l])
                2'd0:
                begin
                    cw = ln.x;
                    sw = ln.y;
                end
                2'd1:
                begin
                    cw = -ln.y;
                    sw = ln.x;
                end
                2'd2:
                begin
                    cw = -ln.x;
                    sw = -ln.y;
                end
                default:
                begin
                    cw = ln.y;
                    sw = -ln.x;
                end
            endcase
            c_next[l] = cw[patd_pkg::CS_BITS-1:0];
            s_next[l] = sw[patd_pkg::CS_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (move[QS])
        begin
            c_reg <= c_next;
            s_reg <= s_next;
            bx_reg[QS]  <= st[patd_pkg::CORDIC_STEPS].bx;
            ty_reg[QS]  <= st[patd_pkg::CORDIC_STEPS].ty;
            dir_reg[QS] <= st[patd_pkg::CORDIC_STEPS].dir;
        end
        for (int i = MS; i <= RS; i++)
        begin
            if (move[i])
            begin
                bx_reg[i]  <= bx_reg[i-1];
                ty_reg[i]  <= ty_reg[i-1];
                dir_reg[i] <= dir_reg[i-1];
            end
        end
    end

    for (genvar l = 0; l < patd_pkg::LANES; l++)
    begin : g_scale
        patd_scale u_scale
        (
            .clk    (clk),
            .en_mul (move[MS]),
            .en_rnd (move[RS]),
            .len    (link_length_reg),
            .c      (c_reg[l]),
            .s      (s_reg[l]),
            .rc     (rc[l]),
            .rs     (rs[l])
        );
    end

    always_comb
    begin
        result_next.tip_x     = bx_reg[RS] - rs[0] - rs[1] - rs[2];
        result_next.tip_y     = ty_reg[RS] + rc[0] + rc[1] + rc[2];
        result_next.direction = dir_reg[RS];
    end

    always_ff @(posedge clk)
    begin
        if (move[OS])
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg[OS];
    assign result       = result_reg;

    `PATD_ASSERT_NXT(a_accept_fills, clk, rst_n, item_valid && !item_stall, valid_reg[0])
    `PATD_ASSERT_NXT(a_first_holds, clk, rst_n, valid_reg[1] && !move[2], valid_reg[1])
    `PATD_ASSERT_NXT(a_out_holds, clk, rst_n, result_valid && result_stall, result_valid)
    `PATD_ASSERT_IMP(a_zero_dir, clk, rst_n, result_valid && link_length_reg == '0,
                     result.direction == '0)

endmodule

[hdl/patd_cordic_step.sv]
`timescale 1ns / 1ps
module patd_cordic_step
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [4:0]             step,
    input  patd_pkg::stage_t       d,
    output patd_pkg::stage_t       q
);

    patd_pkg::stage_t q_reg;
    patd_pkg::stage_t q_next;

    always_comb
    begin
        q_next = d;
        for (int l = 0; l < patd_pkg::LANES; l++)
        begin
            if (!d.lane[l].z[patd_pkg::Z_BITS-1])
            begin
                q_next.lane[l].x = d.lane[l].x - (d.lane[l].y >>> step);
                q_next.lane[l].y = d.lane[l].y + (d.lane[l].x >>> step);
                q_next.lane[l].z = d.lane[l].z - patd_pkg::atan_step(step);
            end
            else
            begin
                q_next.lane[l].x = d.lane[l].x + (d.lane[l].y >>> step);
                q_next.lane[l].y = d.lane[l].y - (d.lane[l].x >>> step);
                q_next.lane[l].z = d.lane[l].z + patd_pkg::atan_step(step);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

[hdl/patd_scale.sv]
`timescale 1ns / 1ps
module patd_scale
(
    input  logic                                      clk,
    input  logic                                      en_mul,
    input  logic                                      en_rnd,
    input  logic [patd_pkg::LEN_BITS-1:0]             len,
    input  logic signed [patd_pkg::CS_BITS-1:0]       c,
    input  logic signed [patd_pkg::CS_BITS-1:0]       s,
    output logic signed [patd_pkg::COORD_BITS-1:0]    rc,
    output logic signed [patd_pkg::COORD_BITS-1:0]    rs
);

    logic signed [patd_pkg::PROD_BITS-1:0]  pc_reg;
    logic signed [patd_pkg::PROD_BITS-1:0]  ps_reg;
    logic signed [patd_pkg::PROD_BITS-1:0]  pc_next;
    logic signed [patd_pkg::PROD_BITS-1:0]  ps_next;
    logic signed [patd_pkg::COORD_BITS-1:0] rc_reg;
    logic signed [patd_pkg::COORD_BITS-1:0] rs_reg;

    assign pc_next = patd_pkg::PROD_BITS'($signed({1'b0, len}) * c);
    assign ps_next = patd_pkg::PROD_BITS'($signed({1'b0, len}) * s);

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            pc_reg <= pc_next;
            ps_reg <= ps_next;
        end
        if (en_rnd)
        begin
            rc_reg <= patd_pkg::round_q30(pc_reg);
            rs_reg <= patd_pkg::round_q30(ps_reg);
        end
    end

    assign rc = rc_reg;
    assign rs = rs_reg;

endmodule
